>>> design/rltt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rltt_pkg: redo log transaction tracker shared definitions
// Widths, codes, state encoding and the command/status structs passed
// between the controller, the datapath and the register block.
// ----------------------------------------------------------------------------
package rltt_pkg;

   localparam int LOG_ENTRIES = 30;
   localparam int IDX_W       = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;

   localparam int CMD_W     = 2;
   localparam int BLK_W     = 32;
   localparam int STATUS_W  = 3;
   localparam int PHASE_W   = 2;
   localparam int COUNT_W   = 5;
   localparam int ACT_W     = 6;
   localparam int SMALL_W   = 5;
   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;
   localparam int NEED_W    = 13;

   typedef enum logic [CMD_W-1:0] {
      CMD_BEGIN = 2'd0,
      CMD_END   = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_WAIT      = 3'd1,
      STATUS_TOO_BIG   = 3'd2,
      STATUS_OUTSIDE   = 3'd3,
      STATUS_UNMATCHED = 3'd4,
      STATUS_COMMIT    = 3'd5
   } status_type;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_COPY    = 2'd0,
      PHASE_HEADER  = 2'd1,
      PHASE_INSTALL = 2'd2,
      PHASE_CLEAR   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      REG_LOG_START  = 2'd0,
      REG_LOG_BLOCKS = 2'd1,
      REG_RESERVE    = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      OUT_SIMPLE,
      OUT_WRITE,
      OUT_COPY,
      OUT_HEADER,
      OUT_INSTALL,
      OUT_CLEAR
   } out_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RESP,
      ST_SEARCH,
      ST_WRITE,
      ST_WRESP,
      ST_COPY,
      ST_HEADER,
      ST_INSTALL,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [BLK_W-1:0]   log_start;
      logic [SMALL_W-1:0] log_blocks;
      logic [SMALL_W-1:0] reserve_per_op;
   } cfg_type;

   typedef struct packed {
      logic         act_inc;
      logic         act_dec;
      logic         blk_load;
      logic         idx_clr;
      logic         idx_inc;
      logic         new_set;
      logic         new_clr;
      logic         mem_we;
      logic         cnt_clr;
      logic         out_load;
      out_kind_type out_kind;
      status_type   out_status;
      logic         out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic begin_ok;
      logic too_big;
      logic active_zero;
      logic active_one;
      logic count_zero;
      logic match;
      logic idx_last;
      logic out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

>>> design/redo_log_transaction_tracker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// redo_log_transaction_tracker_unit: redo log transaction tracker
// Write-ahead redo log bookkeeping with group commit: begin/end/write
// commands in, status items and commit step items out.
// ----------------------------------------------------------------------------
// One item is worked on at a time; req_stall is high until its last result
// has been loaded into the output register. Command 3 gives no result. An
// accepted write scans the table entries (up to the current entry count,
// at most 29); the single-port entry table scans one entry per cycle. A
// committing end emits 2c + 2 items for c logged entries, one per cycle
// while the output is not stalled. No clearing pass follows reset.
module redo_log_transaction_tracker_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [rltt_pkg::CMD_W-1:0]     req_command,
   input  wire logic [rltt_pkg::BLK_W-1:0]     req_block_number,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [rltt_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [rltt_pkg::PHASE_W-1:0]   rsp_phase,
   output logic      [rltt_pkg::BLK_W-1:0]     rsp_source_block,
   output logic      [rltt_pkg::BLK_W-1:0]     rsp_dest_block,
   output logic      [rltt_pkg::SMALL_W-1:0]   rsp_entry_index,
   output logic                                rsp_new_entry,
   output logic      [rltt_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                                rsp_last,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [rltt_pkg::PADDR_W-1:0]   csr_paddr,
   input  wire logic [rltt_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic      [rltt_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);

   rltt_pkg::cfg_type     cfg;
   rltt_pkg::dp_cmd_type  dp_cmd;
   rltt_pkg::dp_stat_type dp_stat;

   rltt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rltt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .stat        (dp_stat),
      .cmd         (dp_cmd)
   );

   rltt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (dp_cmd),
      .req_block_number (req_block_number),
      .rsp_stall        (rsp_stall),
      .stat             (dp_stat),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_phase        (rsp_phase),
      .rsp_source_block (rsp_source_block),
      .rsp_dest_block   (rsp_dest_block),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_new_entry    (rsp_new_entry),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

>>> design/rltt_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rltt_csr: configuration registers
// APB-style register block holding log start, log size and per-operation
// reservation.
// ----------------------------------------------------------------------------
module rltt_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [rltt_pkg::PADDR_W-1:0]  csr_paddr,
   input  wire logic [rltt_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic      [rltt_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                               csr_pready,
   output rltt_pkg::cfg_type                  cfg
);

   rltt_pkg::cfg_type       cfg_ff, cfg_in;
   rltt_pkg::reg_index_type reg_index;
   logic                    wr_en;

   assign reg_index  = rltt_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            rltt_pkg::REG_LOG_START:  cfg_in.log_start = csr_pwdata;
            rltt_pkg::REG_LOG_BLOCKS:
               cfg_in.log_blocks = csr_pwdata[rltt_pkg::SMALL_W-1:0];
            rltt_pkg::REG_RESERVE:
               cfg_in.reserve_per_op = csr_pwdata[rltt_pkg::SMALL_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         rltt_pkg::REG_LOG_START:  csr_prdata = cfg_ff.log_start;
         rltt_pkg::REG_LOG_BLOCKS:
            csr_prdata = rltt_pkg::PDATA_W'(cfg_ff.log_blocks);
         rltt_pkg::REG_RESERVE:
            csr_prdata = rltt_pkg::PDATA_W'(cfg_ff.reserve_per_op);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.log_start      <= rltt_pkg::BLK_W'(2);
         cfg_ff.log_blocks     <= rltt_pkg::SMALL_W'(31);
         cfg_ff.reserve_per_op <= rltt_pkg::SMALL_W'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> design/rltt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rltt_datapath: entry table, counters and result register
// Holds the logged block table, entry and active-operation counts, the
// scan index and the output item register.
// ----------------------------------------------------------------------------
module rltt_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rltt_pkg::cfg_type              cfg,
   input  wire rltt_pkg::dp_cmd_type           cmd,
   input  wire logic [rltt_pkg::BLK_W-1:0]     req_block_number,
   input  wire logic                           rsp_stall,
   output rltt_pkg::dp_stat_type               stat,
   output logic                                rsp_valid,
   output logic      [rltt_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [rltt_pkg::PHASE_W-1:0]   rsp_phase,
   output logic      [rltt_pkg::BLK_W-1:0]     rsp_source_block,
   output logic      [rltt_pkg::BLK_W-1:0]     rsp_dest_block,
   output logic      [rltt_pkg::SMALL_W-1:0]   rsp_entry_index,
   output logic                                rsp_new_entry,
   output logic      [rltt_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                                rsp_last
);

   localparam logic [rltt_pkg::IDX_W-1:0] LAST_SLOT =
      rltt_pkg::IDX_W'(rltt_pkg::LOG_ENTRIES - 1);

   logic [rltt_pkg::BLK_W-1:0]    mem [rltt_pkg::LOG_ENTRIES];
   logic [rltt_pkg::BLK_W-1:0]    rd_data_ff;

   logic [rltt_pkg::ACT_W-1:0]    active_ff, active_in;
   logic [rltt_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [rltt_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                          new_ff, new_in;
   logic [rltt_pkg::BLK_W-1:0]    blk_ff, blk_in;

   logic                          valid_ff, valid_in;
   logic [rltt_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [rltt_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [rltt_pkg::BLK_W-1:0]    src_ff, src_in;
   logic [rltt_pkg::BLK_W-1:0]    dst_ff, dst_in;
   logic [rltt_pkg::SMALL_W-1:0]  eidx_ff, eidx_in;
   logic                          enew_ff, enew_in;
   logic [rltt_pkg::COUNT_W-1:0]  ecount_ff, ecount_in;
   logic                          last_ff, last_in;

   logic [rltt_pkg::ACT_W:0]      act_p1;
   logic [rltt_pkg::NEED_W-2:0]   reserved;
   logic [rltt_pkg::NEED_W-1:0]   need;
   logic [rltt_pkg::BLK_W-1:0]    slot_blk;

   // admission and size checks
   always_comb begin
      act_p1   = {1'b0, active_ff} + (rltt_pkg::ACT_W + 1)'(1);
      reserved = (rltt_pkg::NEED_W - 1)'(act_p1) *
                 (rltt_pkg::NEED_W - 1)'(cfg.reserve_per_op);
      need     = rltt_pkg::NEED_W'(reserved) + rltt_pkg::NEED_W'(count_ff);

      stat.begin_ok    = (active_ff != '1) &&
                         (need <= rltt_pkg::NEED_W'(rltt_pkg::LOG_ENTRIES));
      stat.too_big     = ((rltt_pkg::COUNT_W + 1)'(count_ff) >=
                          (rltt_pkg::COUNT_W + 1)'(rltt_pkg::LOG_ENTRIES)) ||
                         ((rltt_pkg::COUNT_W + 1)'(count_ff) +
                          (rltt_pkg::COUNT_W + 1)'(1) >=
                          (rltt_pkg::COUNT_W + 1)'(cfg.log_blocks));
      stat.active_zero = (active_ff == '0);
      stat.active_one  = (active_ff == rltt_pkg::ACT_W'(1));
      stat.count_zero  = (count_ff == '0);
      stat.match       = (rd_data_ff == blk_ff);
      stat.idx_last    = ((rltt_pkg::COUNT_W + 1)'(idx_ff) +
                          (rltt_pkg::COUNT_W + 1)'(1)) ==
                         (rltt_pkg::COUNT_W + 1)'(count_ff);
      stat.out_free    = !valid_ff || !rsp_stall;
   end

   // state counters
   always_comb begin
      active_in = active_ff;
      if (cmd.act_inc) begin
         active_in = active_ff + rltt_pkg::ACT_W'(1);
      end else if (cmd.act_dec) begin
         active_in = active_ff - rltt_pkg::ACT_W'(1);
      end

      count_in = count_ff;
      if (cmd.cnt_clr) begin
         count_in = '0;
      end else if (cmd.mem_we && new_ff) begin
         count_in = count_ff + rltt_pkg::COUNT_W'(1);
      end

      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + rltt_pkg::IDX_W'(1);
      end

      new_in = new_ff;
      if (cmd.new_set) begin
         new_in = 1'b1;
      end else if (cmd.new_clr) begin
         new_in = 1'b0;
      end

      blk_in = cmd.blk_load ? req_block_number : blk_ff;
   end

   // result item
   always_comb begin
      slot_blk  = cfg.log_start + rltt_pkg::BLK_W'(idx_ff) + rltt_pkg::BLK_W'(1);

      status_in = rltt_pkg::STATUS_COMMIT;
      phase_in  = rltt_pkg::PHASE_COPY;
      src_in    = '0;
      dst_in    = '0;
      eidx_in   = '0;
      enew_in   = 1'b0;
      ecount_in = count_ff;
      case (cmd.out_kind)
         rltt_pkg::OUT_SIMPLE: begin
            status_in = cmd.out_status;
         end
         rltt_pkg::OUT_WRITE: begin
            status_in = rltt_pkg::STATUS_OK;
            eidx_in   = rltt_pkg::SMALL_W'(idx_ff);
            enew_in   = new_ff;
         end
         rltt_pkg::OUT_COPY: begin
            src_in = rd_data_ff;
            dst_in = slot_blk;
         end
         rltt_pkg::OUT_HEADER: begin
            phase_in = rltt_pkg::PHASE_HEADER;
            dst_in   = cfg.log_start;
         end
         rltt_pkg::OUT_INSTALL: begin
            phase_in = rltt_pkg::PHASE_INSTALL;
            src_in   = slot_blk;
            dst_in   = rd_data_ff;
         end
         rltt_pkg::OUT_CLEAR: begin
            phase_in  = rltt_pkg::PHASE_CLEAR;
            dst_in    = cfg.log_start;
            ecount_in = '0;
         end
         default: begin
            status_in = cmd.out_status;
         end
      endcase
      last_in = cmd.out_last;

      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we && (idx_ff <= LAST_SLOT)) begin
         mem[idx_ff] <= blk_ff;
      end
      if (idx_in <= LAST_SLOT) begin
         rd_data_ff <= mem[idx_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      new_ff <= new_in;
      blk_ff <= blk_in;
      if (cmd.out_load) begin
         status_ff <= status_in;
         phase_ff  <= phase_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         eidx_ff   <= eidx_in;
         enew_ff   <= enew_in;
         ecount_ff <= ecount_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_phase        = phase_ff;
   assign rsp_source_block = src_ff;
   assign rsp_dest_block   = dst_ff;
   assign rsp_entry_index  = eidx_ff;
   assign rsp_new_entry    = enew_ff;
   assign rsp_entry_count  = ecount_ff;
   assign rsp_last         = last_ff;

endmodule
`default_nettype wire

>>> design/rltt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rltt_ctrl: transaction controller
// Decodes each item, steps the entry scan and the commit sequence, and
// hands result items to the datapath output register.
// ----------------------------------------------------------------------------
module rltt_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [rltt_pkg::CMD_W-1:0]  req_command,
   output logic                             req_stall,
   input  wire rltt_pkg::dp_stat_type       stat,
   output rltt_pkg::dp_cmd_type             cmd
);

   rltt_pkg::state_type  state_ff, state_in;
   rltt_pkg::status_type status_ff, status_in;
   rltt_pkg::cmd_type    req_cmd;

   assign req_cmd   = rltt_pkg::cmd_type'(req_command);
   assign req_stall = (state_ff != rltt_pkg::ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.out_kind   = rltt_pkg::OUT_SIMPLE;
      cmd.out_status = status_ff;

      unique case (state_ff)
         rltt_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  rltt_pkg::CMD_BEGIN: begin
                     state_in = rltt_pkg::ST_RESP;
                     if (stat.begin_ok) begin
                        cmd.act_inc = 1'b1;
                        status_in   = rltt_pkg::STATUS_OK;
                     end else begin
                        status_in = rltt_pkg::STATUS_WAIT;
                     end
                  end
                  rltt_pkg::CMD_END: begin
                     if (stat.active_zero) begin
                        state_in  = rltt_pkg::ST_RESP;
                        status_in = rltt_pkg::STATUS_UNMATCHED;
                     end else begin
                        cmd.act_dec = 1'b1;
                        if (stat.active_one && !stat.count_zero) begin
                           cmd.idx_clr = 1'b1;
                           state_in    = rltt_pkg::ST_COPY;
                        end else begin
                           state_in  = rltt_pkg::ST_RESP;
                           status_in = rltt_pkg::STATUS_OK;
                        end
                     end
                  end
                  rltt_pkg::CMD_WRITE: begin
                     if (stat.too_big) begin
                        state_in  = rltt_pkg::ST_RESP;
                        status_in = rltt_pkg::STATUS_TOO_BIG;
                     end else if (stat.active_zero) begin
                        state_in  = rltt_pkg::ST_RESP;
                        status_in = rltt_pkg::STATUS_OUTSIDE;
                     end else begin
                        cmd.blk_load = 1'b1;
                        cmd.idx_clr  = 1'b1;
                        if (stat.count_zero) begin
                           cmd.new_set = 1'b1;
                           state_in    = rltt_pkg::ST_WRITE;
                        end else begin
                           cmd.new_clr = 1'b1;
                           state_in    = rltt_pkg::ST_SEARCH;
                        end
                     end
                  end
                  default: state_in = rltt_pkg::ST_IDLE;
               endcase
            end
         end
         rltt_pkg::ST_RESP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = rltt_pkg::ST_IDLE;
            end
         end
         rltt_pkg::ST_SEARCH: begin
            if (stat.match) begin
               state_in = rltt_pkg::ST_WRITE;
            end else if (stat.idx_last) begin
               cmd.idx_inc = 1'b1;
               cmd.new_set = 1'b1;
               state_in    = rltt_pkg::ST_WRITE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         rltt_pkg::ST_WRITE: begin
            cmd.mem_we = 1'b1;
            state_in   = rltt_pkg::ST_WRESP;
         end
         rltt_pkg::ST_WRESP: begin
            cmd.out_kind = rltt_pkg::OUT_WRITE;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = rltt_pkg::ST_IDLE;
            end
         end
         rltt_pkg::ST_COPY: begin
            cmd.out_kind = rltt_pkg::OUT_COPY;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               if (stat.idx_last) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = rltt_pkg::ST_HEADER;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         rltt_pkg::ST_HEADER: begin
            cmd.out_kind = rltt_pkg::OUT_HEADER;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = rltt_pkg::ST_INSTALL;
            end
         end
         rltt_pkg::ST_INSTALL: begin
            cmd.out_kind = rltt_pkg::OUT_INSTALL;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               if (stat.idx_last) begin
                  state_in = rltt_pkg::ST_CLEAR;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         rltt_pkg::ST_CLEAR: begin
            cmd.out_kind = rltt_pkg::OUT_CLEAR;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               cmd.cnt_clr  = 1'b1;
               state_in     = rltt_pkg::ST_IDLE;
            end
         end
         default: state_in = rltt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rltt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

endmodule
`default_nettype wire

>>> design/rltt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rltt_checker: port-level checks for the redo log transaction tracker
// Watches the result channel and input stall over time.
// ----------------------------------------------------------------------------
module rltt_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [rltt_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [rltt_pkg::PHASE_W-1:0]   rsp_phase,
   input wire logic [rltt_pkg::COUNT_W-1:0]   rsp_entry_count,
   input wire logic                           rsp_last
);

   // result channel comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled item dropped");

   a_single_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rltt_pkg::STATUS_COMMIT) |->
         rsp_last && (rsp_phase == rltt_pkg::PHASE_COPY))
      else $error("non-commit item not single");

   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rltt_pkg::STATUS_COMMIT) |->
         (rsp_last == (rsp_phase == rltt_pkg::PHASE_CLEAR)) &&
         ((rsp_phase != rltt_pkg::PHASE_CLEAR) || (rsp_entry_count == '0)))
      else $error("commit sequence end malformed");

   // no new item while a commit sequence is still going out
   a_busy_in_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("item accepted mid-commit");

endmodule

bind redo_log_transaction_tracker_unit rltt_checker u_rltt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_phase       (rsp_phase),
   .rsp_entry_count (rsp_entry_count),
   .rsp_last        (rsp_last)
);
`default_nettype wire

>>> sim/redo_log_commit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redo_log_commit_checker: item checker for the redo log transaction tracker
// Watches the command, result and register ports. Keeps its own entry table,
// entry count, open operation count and register copy, works out the status
// and commit step items of every accepted command, and compares each
// delivered item field by field against the oldest one still due.
// ----------------------------------------------------------------------------
module redo_log_commit_checker
   import rltt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [BLK_W-1:0]    req_block_number,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [PHASE_W-1:0]  rsp_phase,
   input  logic [BLK_W-1:0]    rsp_source_block,
   input  logic [BLK_W-1:0]    rsp_dest_block,
   input  logic [SMALL_W-1:0]  rsp_entry_index,
   input  logic                rsp_new_entry,
   input  logic [COUNT_W-1:0]  rsp_entry_count,
   input  logic                rsp_last,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [PADDR_W-1:0]  csr_paddr,
   input  logic [PDATA_W-1:0]  csr_pwdata,
   input  logic [PDATA_W-1:0]  csr_prdata,
   input  logic                csr_pready,
   output int unsigned         fail_count,
   output int unsigned         open_results
);

   typedef struct packed {
      status_type         status;
      phase_type          phase;
      logic [BLK_W-1:0]   source_block;
      logic [BLK_W-1:0]   dest_block;
      logic [SMALL_W-1:0] entry_index;
      logic               new_entry;
      logic [COUNT_W-1:0] entry_count;
      logic               last;
   } log_result_type;

   localparam int unsigned OPS_MAX = (1 << ACT_W) - 1;

   log_result_type   results_due[$];
   logic [BLK_W-1:0] table_blocks[LOG_ENTRIES];
   int unsigned      entries = 0;
   int unsigned      open_ops = 0;
   int unsigned      fails = 0;
   cfg_type          regs;

   function automatic void add_result(status_type status, phase_type phase,
         logic [BLK_W-1:0] src, logic [BLK_W-1:0] dst, int unsigned idx,
         logic added, int unsigned count, logic last);
      log_result_type r;
      r.status       = status;
      r.phase        = phase;
      r.source_block = src;
      r.dest_block   = dst;
      r.entry_index  = SMALL_W'(idx);
      r.new_entry    = added;
      r.entry_count  = COUNT_W'(count);
      r.last         = last;
      results_due.push_back(r);
   endfunction

   function automatic void apply_log_command(logic [CMD_W-1:0] cmd,
         logic [BLK_W-1:0] blk);
      int unsigned      need;
      int unsigned      slot;
      int unsigned      i;
      logic             added;
      logic [BLK_W-1:0] log_slot;
      case (cmd)
         CMD_BEGIN: begin
            need = entries + (open_ops + 1) * regs.reserve_per_op;
            if (open_ops >= OPS_MAX || need > LOG_ENTRIES) begin
               add_result(STATUS_WAIT, PHASE_COPY, '0, '0, 0, 1'b0, entries, 1'b1);
            end else begin
               open_ops++;
               add_result(STATUS_OK, PHASE_COPY, '0, '0, 0, 1'b0, entries, 1'b1);
            end
         end
         CMD_END: begin
            if (open_ops == 0) begin
               add_result(STATUS_UNMATCHED, PHASE_COPY, '0, '0, 0, 1'b0, entries, 1'b1);
            end else begin
               open_ops--;
               if (open_ops == 0 && entries > 0) begin
                  for (i = 0; i < entries; i++) begin
                     log_slot = regs.log_start + BLK_W'(i + 1);
                     add_result(STATUS_COMMIT, PHASE_COPY, table_blocks[i], log_slot,
                                0, 1'b0, entries, 1'b0);
                  end
                  add_result(STATUS_COMMIT, PHASE_HEADER, '0, regs.log_start, 0, 1'b0,
                             entries, 1'b0);
                  for (i = 0; i < entries; i++) begin
                     log_slot = regs.log_start + BLK_W'(i + 1);
                     add_result(STATUS_COMMIT, PHASE_INSTALL, log_slot, table_blocks[i],
                                0, 1'b0, entries, 1'b0);
                  end
                  add_result(STATUS_COMMIT, PHASE_CLEAR, '0, regs.log_start, 0, 1'b0,
                             0, 1'b1);
                  entries = 0;
               end else begin
                  add_result(STATUS_OK, PHASE_COPY, '0, '0, 0, 1'b0, entries, 1'b1);
               end
            end
         end
         CMD_WRITE: begin
            if (entries >= LOG_ENTRIES || entries + 1 >= regs.log_blocks) begin
               add_result(STATUS_TOO_BIG, PHASE_COPY, '0, '0, 0, 1'b0, entries, 1'b1);
            end else if (open_ops == 0) begin
               add_result(STATUS_OUTSIDE, PHASE_COPY, '0, '0, 0, 1'b0, entries, 1'b1);
            end else begin
               slot = 0;
               while (slot < entries && table_blocks[slot] != blk) slot++;
               added = (slot == entries);
               table_blocks[slot] = blk;
               if (added) entries++;
               add_result(STATUS_OK, PHASE_COPY, '0, '0, slot, added, entries, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [PDATA_W-1:0] reg_value(reg_index_type idx);
      case (idx)
         REG_LOG_START:  return regs.log_start;
         REG_LOG_BLOCKS: return PDATA_W'(regs.log_blocks);
         REG_RESERVE:    return PDATA_W'(regs.reserve_per_op);
         default:        return '0;
      endcase
   endfunction

   function automatic string result_text(logic [STATUS_W-1:0] status,
         logic [PHASE_W-1:0] phase, logic [BLK_W-1:0] src, logic [BLK_W-1:0] dst,
         logic [SMALL_W-1:0] idx, logic added, logic [COUNT_W-1:0] count, logic last);
      return $sformatf("st=%0d ph=%0d src=%h dst=%h idx=%0d new=%0d cnt=%0d last=%0d",
                       status, phase, src, dst, idx, added, count, last);
   endfunction

   function automatic void note_failure(string msg);
      fails++;
      if (fails <= 10) $display("%0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin : watch
      log_result_type due;
      reg_index_type  idx;
      if (reset) begin
         results_due.delete();
         entries = 0;
         open_ops = 0;
         regs.log_start = 32'd2;
         regs.log_blocks = 5'd31;
         regs.reserve_per_op = 5'd10;
      end else begin
         idx = reg_index_type'(csr_paddr[PADDR_W-1:2]);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (idx)
                  REG_LOG_START:  regs.log_start = csr_pwdata;
                  REG_LOG_BLOCKS: regs.log_blocks = csr_pwdata[SMALL_W-1:0];
                  REG_RESERVE:    regs.reserve_per_op = csr_pwdata[SMALL_W-1:0];
                  default: ;
               endcase
            end else if (csr_prdata !== reg_value(idx)) begin
               note_failure($sformatf("register %0d read %h, expected %h",
                                      idx, csr_prdata, reg_value(idx)));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               note_failure({"item with none due: ",
                             result_text(rsp_status, rsp_phase, rsp_source_block,
                                         rsp_dest_block, rsp_entry_index, rsp_new_entry,
                                         rsp_entry_count, rsp_last)});
            end else begin
               due = results_due.pop_front();
               if (rsp_status !== due.status || rsp_phase !== due.phase ||
                   rsp_source_block !== due.source_block ||
                   rsp_dest_block !== due.dest_block ||
                   rsp_entry_index !== due.entry_index ||
                   rsp_new_entry !== due.new_entry ||
                   rsp_entry_count !== due.entry_count || rsp_last !== due.last) begin
                  note_failure({"item mismatch\n   expected ",
                                result_text(due.status, due.phase, due.source_block,
                                            due.dest_block, due.entry_index, due.new_entry,
                                            due.entry_count, due.last),
                                "\n   actual   ",
                                result_text(rsp_status, rsp_phase, rsp_source_block,
                                            rsp_dest_block, rsp_entry_index, rsp_new_entry,
                                            rsp_entry_count, rsp_last)});
               end
            end
         end
         if (req_valid && !req_stall) apply_log_command(req_command, req_block_number);
      end
      open_results <= results_due.size();
      fail_count <= fails;
   end

endmodule

>>> sim/redo_log_transaction_tracker_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redo_log_transaction_tracker_unit_test: testbench top for the tracker
// Drives begin, end and write commands and register settings into the unit,
// paces both channels at random, holds off the result side once for a long
// stretch, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module redo_log_transaction_tracker_unit_test;
   import rltt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
   localparam int unsigned      CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned      HOLD_CYCLES  = 300;
   localparam int unsigned      SETTLE_CYCLES = 8;
   localparam int unsigned      RANDOM_ITEMS = 60;
   localparam int unsigned      PHASE_ITEMS  = 30;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_command = CMD_BEGIN;
   logic [BLK_W-1:0]    req_block_number = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b1;
   logic [STATUS_W-1:0] rsp_status;
   logic [PHASE_W-1:0]  rsp_phase;
   logic [BLK_W-1:0]    rsp_source_block;
   logic [BLK_W-1:0]    rsp_dest_block;
   logic [SMALL_W-1:0]  rsp_entry_index;
   logic                rsp_new_entry;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic                rsp_last;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [PADDR_W-1:0]  csr_paddr = '0;
   logic [PDATA_W-1:0]  csr_pwdata = '0;
   logic [PDATA_W-1:0]  csr_prdata;
   logic                csr_pready;
   int unsigned         fail_count;
   int unsigned         open_results;

   logic        calm = 1'b0;
   logic        hold_request = 1'b0;
   logic        hold_taken = 1'b0;
   int unsigned rx_wait = 0;
   int unsigned rx_hold = 0;
   int unsigned cycles = 0;
   int unsigned sent = 0;

   redo_log_transaction_tracker_unit dut (.*);

   redo_log_commit_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side pacing; one long hold-off on request
   always @(posedge clock) begin : rx_pace
      int unsigned gap;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         rx_hold <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         gap = calm ? 0 : $urandom_range(0, 9);
         rx_wait <= gap;
         rsp_stall <= (gap != 0);
      end else if (rx_wait != 0) begin
         rx_wait <= rx_wait - 1;
         rsp_stall <= (rx_wait != 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BLK_W-1:0] blk);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_block_number <= blk;
      do @(posedge clock); while (req_stall);
      if (cmd != CMD_UNUSED) sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input reg_index_type idx,
                             input logic [PDATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= PADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reg(input reg_index_type idx, input logic [PDATA_W-1:0] value);
      csr_access(1'b1, idx, value);
      csr_access(1'b0, idx, '0);
   endtask

   task automatic pick_config(input int unsigned phase);
      logic [BLK_W-1:0] start;
      int unsigned      blocks;
      int unsigned      reserve;
      case ($urandom_range(0, 3))
         0: start = '0;
         1: start = '1;
         2: start = 32'hFFFF_FFF0 | $urandom_range(0, 15);
         default: start = $urandom();
      endcase
      blocks = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 31) : $urandom_range(20, 31);
      reserve = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 9);
      if (phase == 0) begin
         start = '0;
         blocks = 31;
         reserve = 1;
      end
      set_reg(REG_LOG_START, start);
      set_reg(REG_LOG_BLOCKS, blocks);
      set_reg(REG_RESERVE, reserve);
   endtask

   function automatic logic [BLK_W-1:0] pick_block(logic [BLK_W-1:0] base);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom();
         default: return base + $urandom_range(0, 5);
      endcase
   endfunction

   // bracketed operations with repeated blocks, some stray commands
   task automatic run_txn();
      int unsigned      ops;
      int unsigned      early;
      int unsigned      late;
      logic [BLK_W-1:0] base;
      base = $urandom();
      if ($urandom_range(0, 7) == 0) begin
         send_req(CMD_W'($urandom_range(0, 3)), $urandom());
      end else begin
         ops = $urandom_range(1, 3);
         early = $urandom_range(0, 10);
         late = $urandom_range(0, 4);
         repeat (ops) send_req(CMD_BEGIN, $urandom());
         repeat (early) send_req(CMD_WRITE, pick_block(base));
         send_req(CMD_END, $urandom());
         repeat (late) send_req(CMD_WRITE, pick_block(base));
         repeat (ops - 1) send_req(CMD_END, $urandom());
      end
   endtask

   initial begin : stimulus
      int unsigned      phase;
      int unsigned      target;
      int unsigned      stop;
      int unsigned      i;
      logic [BLK_W-1:0] base;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, REG_LOG_START, '0);
      csr_access(1'b0, REG_LOG_BLOCKS, '0);
      csr_access(1'b0, REG_RESERVE, '0);

      // defaults: unmatched end, outside write, ignored command, space limit,
      // absorption, nested commit, empty commit
      send_req(CMD_END, 32'h0000_0000);
      send_req(CMD_WRITE, 32'h0000_0000);
      send_req(CMD_UNUSED, 32'hFFFF_FFFF);
      repeat (4) send_req(CMD_BEGIN, $urandom());
      send_req(CMD_WRITE, 32'hFFFF_FFFF);
      send_req(CMD_WRITE, 32'h0000_0000);
      send_req(CMD_WRITE, 32'hFFFF_FFFF);
      send_req(CMD_WRITE, 32'hAAAA_AAAA);
      send_req(CMD_WRITE, 32'h5555_5555);
      send_req(CMD_BEGIN, 32'hFFFF_FFFF);
      repeat (3) send_req(CMD_END, $urandom());
      send_req(CMD_END, 32'hFFFF_FFFF);
      send_req(CMD_BEGIN, 32'h0000_0000);
      send_req(CMD_END, 32'h0000_0000);
      drain();

      // smallest log area, header at the top of the block space
      set_reg(REG_LOG_BLOCKS, 2);
      set_reg(REG_LOG_START, 32'hFFFF_FFFF);
      send_req(CMD_BEGIN, $urandom());
      send_req(CMD_WRITE, 32'h1234_5678);
      send_req(CMD_WRITE, 32'h1234_5678);
      send_req(CMD_END, $urandom());
      send_req(CMD_WRITE, 32'h8765_4321);
      drain();

      // full table, widest reservation, longest commit
      set_reg(REG_LOG_BLOCKS, 31);
      set_reg(REG_RESERVE, 30);
      set_reg(REG_LOG_START, 32'hFFFF_FFF0);
      base = $urandom();
      send_req(CMD_BEGIN, $urandom());
      send_req(CMD_BEGIN, $urandom());
      for (i = 0; i < LOG_ENTRIES; i++) send_req(CMD_WRITE, base + BLK_W'(i));
      send_req(CMD_WRITE, base);
      send_req(CMD_END, $urandom());
      drain();

      // no reservation: open operations saturate
      set_reg(REG_RESERVE, 0);
      repeat (64) send_req(CMD_BEGIN, $urandom());
      send_req(CMD_WRITE, $urandom());
      send_req(CMD_WRITE, $urandom());
      repeat (64) send_req(CMD_END, $urandom());
      drain();

      phase = 0;
      target = sent + RANDOM_ITEMS;
      while (sent < target) begin
         calm <= (phase % 4 == 1);
         if (phase == 1) hold_request <= 1'b1;
         pick_config(phase);
         stop = sent + PHASE_ITEMS;
         while (sent < stop) run_txn();
         drain();
         phase++;
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
